// ----- hw/rtl/iipe_pkg.sv -----
// Shared types, codes and constants for the inline image payload extractor.
package iipe_pkg;

    localparam int DIM_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 40;

    localparam int CFG_IDX_W = 3;
    localparam int RES_MAX   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTERED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPONENTS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BPC        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd5;

    localparam logic [5:0] BPC_RESET = 6'd8;

    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_I = 8'h49;

    typedef enum logic [1:0] {
        K_PAYLOAD = 2'd0,
        K_END     = 2'd1,
        K_BACK    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_BODY    = 2'd1,
        PH_TRAIL   = 2'd2,
        PH_AFTER_E = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_WAIT     = 3'd0,
        ST_EMIT     = 3'd1,
        ST_LEN_MUL  = 3'd2,
        ST_LEN_ACC  = 3'd3,
        ST_LEN_LOAD = 3'd4
    } ctrl_state_t;

    typedef struct packed {
        logic step;
        logic pop;
        logic len_mul;
        logic len_acc;
        logic len_load;
    } cmd_t;

    typedef struct packed {
        logic has_out;
        logic need_len;
        logic last;
        logic len_pend;
        logic acc_done;
    } sts_t;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'd0, 8'd9, 8'd10, 8'd12, 8'd13, 8'd32};
    endfunction

endpackage

// ----- hw/rtl/iipe_datapath.sv -----
// Datapath: configuration, image state, result buffer and length multiplier.
module iipe_datapath #(
    parameter int DIM_BITS   = iipe_pkg::DIM_BITS_DEF,
    parameter int COUNT_BITS = iipe_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [iipe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_BITS-1:0]            cfg_wdata,
    input  logic [7:0]                     data_byte,
    input  logic                           end_of_stream,
    input  logic                           begin_req,
    input  iipe_pkg::cmd_t                 cmd,
    output iipe_pkg::sts_t                 sts,
    output logic [7:0]                     out_byte,
    output logic [1:0]                     kind,
    output logic                           last_of_run
);
    import iipe_pkg::*;

    localparam int CB_W  = 8;
    localparam int PR_W  = DIM_BITS + CB_W;
    localparam int ROW_W = DIM_BITS + 5;
    localparam int PW    = 2 * DIM_BITS + 5;
    localparam int MW    = (PW > COUNT_BITS) ? PW : COUNT_BITS;
    localparam int BIT_W = (DIM_BITS > 1) ? $clog2(DIM_BITS) : 1;
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(DIM_BITS - 1);
    localparam logic [MW-1:0] CMAX = MW'({COUNT_BITS{1'b1}});

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_E    = 2'd1;
    localparam logic [1:0] HELD_EI   = 2'd2;

    // configuration
    logic                filtered_reg;
    logic                image_mask_reg;
    logic [2:0]          color_components_reg;
    logic [5:0]          sample_bits_reg;
    logic [DIM_BITS-1:0] image_width_reg;
    logic [DIM_BITS-1:0] image_height_reg;

    // image state
    phase_t              phase_reg, phase_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic                scan_reg, scan_next;
    logic                prev_reg, prev_next;
    logic [1:0]          held_reg, held_next;

    // result buffer
    logic [7:0]          res_byte_reg [0:RES_MAX-1];
    kind_t               res_kind_reg [0:RES_MAX-1];
    logic [1:0]          res_cnt_reg;
    logic [1:0]          res_idx_reg;
    logic                len_pend_reg;

    // length unit
    logic [DIM_BITS-1:0] w_s_reg;
    logic [DIM_BITS-1:0] h_s_reg;
    logic [CB_W-1:0]     cb_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [MW-1:0]       acc_reg;
    logic [BIT_W-1:0]    bit_reg;

    // step logic
    logic [7:0]          rb [0:RES_MAX-1];
    kind_t               rk [0:RES_MAX-1];
    logic [1:0]          n;
    logic                known;
    logic                need_len;
    logic [2:0]          comp_e;
    logic [5:0]          bpc_e;
    logic [CB_W-1:0]     cb_e;
    logic [PR_W-1:0]     prod;
    logic [MW-1:0]       addend;

    always_comb
    begin
        comp_e = color_components_reg;
        bpc_e  = sample_bits_reg;
        known  = 1'b1;
        if (filtered_reg)
        begin
            known = 1'b0;
        end
        else if (image_mask_reg)
        begin
            comp_e = 3'd1;
            bpc_e  = 6'd1;
        end
        else if (!(color_components_reg inside {3'd1, 3'd3, 3'd4}))
        begin
            known = 1'b0;
        end
        if (image_width_reg == '0 || image_height_reg == '0 || bpc_e == '0)
        begin
            known = 1'b0;
        end
        cb_e = CB_W'(comp_e) * CB_W'(bpc_e);
    end

    always_comb
    begin
        for (int i = 0; i < RES_MAX; i++)
        begin
            rb[i] = '0;
            rk[i] = K_PAYLOAD;
        end
        n          = '0;
        phase_next = phase_reg;
        rem_next   = rem_reg;
        scan_next  = scan_reg;
        prev_next  = prev_reg;
        held_next  = held_reg;
        need_len   = 1'b0;

        if (begin_req)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rb[n] = '0; rk[n] = K_END; n = n + 2'd1;
            end
            held_next  = HELD_NONE;
            prev_next  = 1'b1;
            rem_next   = '0;
            scan_next  = !known;
            phase_next = PH_BODY;
            if (end_of_stream)
            begin
                rb[n] = '0; rk[n] = K_END; n = n + 2'd1;
                phase_next = PH_IDLE;
            end
            else
            begin
                need_len = known;
            end
        end
        else if (phase_reg == PH_IDLE)
        begin
            if (!end_of_stream)
            begin
                rb[n] = data_byte; rk[n] = K_BACK; n = n + 2'd1;
            end
        end
        else if (phase_reg == PH_BODY && !scan_reg)
        begin
            if (end_of_stream)
            begin
                rb[n] = '0; rk[n] = K_END; n = n + 2'd1;
                phase_next = PH_IDLE; held_next = HELD_NONE; rem_next = '0;
            end
            else
            begin
                rb[n] = data_byte; rk[n] = K_PAYLOAD; n = n + 2'd1;
                rem_next = rem_reg - COUNT_BITS'(rem_reg != '0);
                if (rem_next == '0)
                begin
                    phase_next = PH_TRAIL;
                end
            end
        end
        else if (phase_reg == PH_TRAIL)
        begin
            if (end_of_stream)
            begin
                rb[n] = '0; rk[n] = K_END; n = n + 2'd1;
                phase_next = PH_IDLE; held_next = HELD_NONE; rem_next = '0;
            end
            else if (data_byte == CH_E)
            begin
                phase_next = PH_AFTER_E;
            end
            else if (!is_space(data_byte))
            begin
                rb[n] = '0; rk[n] = K_END; n = n + 2'd1;
                phase_next = PH_IDLE; held_next = HELD_NONE; rem_next = '0;
                rb[n] = data_byte; rk[n] = K_BACK; n = n + 2'd1;
            end
        end
        else if (phase_reg == PH_AFTER_E)
        begin
            rb[n] = '0; rk[n] = K_END; n = n + 2'd1;
            phase_next = PH_IDLE; held_next = HELD_NONE; rem_next = '0;
            if (!end_of_stream && data_byte != CH_I)
            begin
                rb[n] = data_byte; rk[n] = K_BACK; n = n + 2'd1;
            end
        end
        else
        begin
            // terminator scan
            if (end_of_stream)
            begin
                if (held_reg == HELD_E)
                begin
                    rb[n] = CH_E; rk[n] = K_PAYLOAD; n = n + 2'd1;
                end
                rb[n] = '0; rk[n] = K_END; n = n + 2'd1;
                phase_next = PH_IDLE; held_next = HELD_NONE; rem_next = '0;
            end
            else if (held_reg == HELD_E && data_byte == CH_I)
            begin
                held_next = HELD_EI;
            end
            else if (held_reg == HELD_EI && is_space(data_byte))
            begin
                rb[n] = '0; rk[n] = K_END; n = n + 2'd1;
                phase_next = PH_IDLE; held_next = HELD_NONE; rem_next = '0;
                rb[n] = data_byte; rk[n] = K_BACK; n = n + 2'd1;
            end
            else
            begin
                if (held_reg != HELD_NONE)
                begin
                    rb[n] = CH_E; rk[n] = K_PAYLOAD; n = n + 2'd1;
                    prev_next = 1'b0;
                    held_next = HELD_NONE;
                end
                if (held_reg == HELD_EI)
                begin
                    rb[n] = CH_I; rk[n] = K_PAYLOAD; n = n + 2'd1;
                end
                if (data_byte == CH_E && prev_next)
                begin
                    held_next = HELD_E;
                end
                else
                begin
                    rb[n] = data_byte; rk[n] = K_PAYLOAD; n = n + 2'd1;
                    prev_next = is_space(data_byte);
                end
            end
        end
    end

    assign prod   = PR_W'(w_s_reg) * PR_W'(cb_reg);
    assign addend = h_s_reg[bit_reg] ? MW'(row_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filtered_reg         <= 1'b0;
            image_mask_reg       <= 1'b0;
            color_components_reg <= '0;
            sample_bits_reg      <= BPC_RESET;
            image_width_reg      <= '0;
            image_height_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILTERED:   filtered_reg         <= cfg_wdata[0];
                CFG_IMAGE_MASK: image_mask_reg       <= cfg_wdata[0];
                CFG_COMPONENTS: color_components_reg <= cfg_wdata[2:0];
                CFG_BPC:        sample_bits_reg      <= cfg_wdata[5:0];
                CFG_WIDTH:      image_width_reg      <= cfg_wdata;
                CFG_HEIGHT:     image_height_reg     <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            rem_reg      <= '0;
            scan_reg     <= 1'b0;
            prev_reg     <= 1'b1;
            held_reg     <= HELD_NONE;
            res_cnt_reg  <= '0;
            res_idx_reg  <= '0;
            len_pend_reg <= 1'b0;
            bit_reg      <= '0;
        end
        else
        begin
            if (cmd.step)
            begin
                phase_reg    <= phase_next;
                rem_reg      <= rem_next;
                scan_reg     <= scan_next;
                prev_reg     <= prev_next;
                held_reg     <= held_next;
                res_cnt_reg  <= n;
                res_idx_reg  <= '0;
                len_pend_reg <= need_len;
            end
            else if (cmd.pop)
            begin
                res_idx_reg <= res_idx_reg + 2'd1;
            end
            if (cmd.len_mul)
            begin
                bit_reg <= BIT_TOP;
            end
            else if (cmd.len_acc)
            begin
                bit_reg <= bit_reg - BIT_W'(1);
            end
            if (cmd.len_load)
            begin
                rem_reg <= (acc_reg > CMAX) ? CMAX[COUNT_BITS-1:0] : acc_reg[COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            for (int i = 0; i < RES_MAX; i++)
            begin
                res_byte_reg[i] <= rb[i];
                res_kind_reg[i] <= rk[i];
            end
            if (begin_req)
            begin
                w_s_reg <= image_width_reg;
                h_s_reg <= image_height_reg;
                cb_reg  <= cb_e;
            end
        end
        if (cmd.len_mul)
        begin
            row_reg <= ROW_W'((prod + PR_W'(7)) >> 3);
            acc_reg <= '0;
        end
        else if (cmd.len_acc)
        begin
            acc_reg <= {acc_reg[MW-2:0], 1'b0} + addend;
        end
    end

    always_comb
    begin
        sts.has_out  = (n != '0);
        sts.need_len = need_len;
        sts.last     = (res_idx_reg == res_cnt_reg - 2'd1);
        sts.len_pend = len_pend_reg;
        sts.acc_done = (bit_reg == '0);
    end

    assign out_byte    = res_byte_reg[res_idx_reg];
    assign kind        = res_kind_reg[res_idx_reg];
    assign last_of_run = sts.last;

endmodule

// ----- hw/rtl/iipe_ctrl.sv -----
// Controller: sequences byte intake, result delivery and the length computation.
module iipe_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           data_valid,
    output logic           data_stall,
    output logic           result_valid,
    input  logic           result_stall,
    input  iipe_pkg::sts_t sts,
    output iipe_pkg::cmd_t cmd
);
    import iipe_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        data_stall   = 1'b1;
        result_valid = 1'b0;
        case (state_reg)
            ST_WAIT:
            begin
                data_stall = 1'b0;
                if (data_valid)
                begin
                    cmd.step = 1'b1;
                    if (sts.has_out)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (sts.need_len)
                    begin
                        state_next = ST_LEN_MUL;
                    end
                end
            end
            ST_EMIT:
            begin
                result_valid = 1'b1;
                if (!result_stall)
                begin
                    cmd.pop = 1'b1;
                    if (sts.last)
                    begin
                        state_next = sts.len_pend ? ST_LEN_MUL : ST_WAIT;
                    end
                end
            end
            ST_LEN_MUL:
            begin
                cmd.len_mul = 1'b1;
                state_next  = ST_LEN_ACC;
            end
            ST_LEN_ACC:
            begin
                cmd.len_acc = 1'b1;
                if (sts.acc_done)
                begin
                    state_next = ST_LEN_LOAD;
                end
            end
            ST_LEN_LOAD:
            begin
                cmd.len_load = 1'b1;
                state_next   = ST_WAIT;
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

endmodule

// ----- hw/rtl/inline_image_payload_extractor.sv -----
// Top level: inline image payload extractor, controller plus datapath.
// A byte transaction is taken while the controller waits; its 0 to 3 results follow one per cycle
// while result_stall is low, the first in the cycle after the byte is taken.
// A begin byte with a fixed payload length then stalls input for the length steps:
// width*components*bpc, a shift-add over the height bits, then a load of the count.
// Reset: no image in progress, configuration at its defaults (sample depth 8).
module inline_image_payload_extractor #(
    parameter int DIM_BITS   = iipe_pkg::DIM_BITS_DEF,
    parameter int COUNT_BITS = iipe_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [iipe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_BITS-1:0]            cfg_wdata,
    input  logic                           data_valid,
    output logic                           data_stall,
    input  logic [7:0]                     data_byte,
    input  logic                           end_of_stream,
    input  logic                           begin_req,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [7:0]                     out_byte,
    output logic [1:0]                     kind,
    output logic                           last_of_run
);
    import iipe_pkg::*;

    cmd_t cmd;
    sts_t sts;

    iipe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_stall   (data_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    iipe_datapath #(
        .DIM_BITS   (DIM_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .begin_req     (begin_req),
        .cmd           (cmd),
        .sts           (sts),
        .out_byte      (out_byte),
        .kind          (kind),
        .last_of_run   (last_of_run)
    );

endmodule
